FILE: hw/rtl/aees_pkg.sv
// Shared types and constants of the alarm entry/exit state machine.
// Holds the item structs, event and request codes, and register indexes.
// No dependencies.
`default_nettype none

package aees_pkg;

  localparam int unsigned NUM_TGT_FIELDS = 3;
  localparam int unsigned TARGETS_DEF    = 3;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned DLY_W      = 24;
  localparam int unsigned DIST_W     = 15;
  localparam int unsigned OPT_W      = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_EXIT_DELAY   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_DELAY  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIG_TIMEOUT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOITER_THR   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NEAR_DIST    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_OPTIONS      = 3'd5;

  localparam int unsigned OPT_AUTO_REARM = 0;
  localparam int unsigned OPT_LOITER_ALR = 1;
  localparam int unsigned OPT_REMINDER   = 2;
  localparam int unsigned OPT_SIREN      = 3;

  localparam logic [DLY_W-1:0]  EXIT_DELAY_RST   = 24'd30000;
  localparam logic [DLY_W-1:0]  ENTRY_DELAY_RST  = 24'd30000;
  localparam logic [DLY_W-1:0]  TRIG_TIMEOUT_RST = 24'd180000;
  localparam logic [DLY_W-1:0]  LOITER_THR_RST   = 24'd10000;
  localparam logic [DIST_W-1:0] NEAR_DIST_RST    = 15'd2000;
  localparam logic [OPT_W-1:0]  OPTIONS_RST      = 4'd8;

  localparam logic [TIME_W-1:0] REMINDER_MS = 32'd1800000;
  localparam logic [TIME_W-1:0] PRESENCE_MS = 32'd10000;

  localparam int unsigned OQ_DEPTH = 4;

  typedef enum logic [1:0] {
    REQ_TICK,
    REQ_ARM,
    REQ_DISARM,
    REQ_FRAME
  } req_e;

  typedef enum logic [3:0] {
    EV_NONE,
    EV_ARMING,
    EV_ARMED_NOW,
    EV_ARMED_DELAY,
    EV_DISARMED,
    EV_REJECTED,
    EV_ENTRY,
    EV_TRIGGERED,
    EV_SIL_REARM,
    EV_SIL_DISARM,
    EV_LOITER,
    EV_REMINDER
  } event_e;

  typedef struct packed {
    req_e               req_type;
    logic               immediate;
    logic               home_request;
    logic [1:0]         target_count;
    logic               t0_valid;
    logic signed [15:0] t0_y;
    logic               t1_valid;
    logic signed [15:0] t1_y;
    logic               t2_valid;
    logic signed [15:0] t2_y;
  } req_t;

  typedef struct packed {
    event_e     event_code;
    logic [2:0] panel_state;
    logic       home_active;
    logic       siren_on;
    logic       loiter_flag;
    logic       last_result;
  } rsp_t;

  typedef struct packed {
    logic push;
    logic two;
    rsp_t first;
    rsp_t second;
  } push_t;

endpackage

`default_nettype wire

FILE: hw/rtl/aees_lane.sv
// One radar target lane: decides whether a target is valid and near.
// Depends on aees_pkg for the distance width.
`default_nettype none

module aees_lane (
  input  logic                       valid_i,
  input  logic signed [15:0]         y_i,
  input  logic [aees_pkg::DIST_W-1:0] near_dist_i,
  output logic                       near_o
);
  import aees_pkg::*;

  logic signed [15:0] limit;

  assign limit  = signed'({1'b0, near_dist_i});
  assign near_o = valid_i && (y_i > 16'sd0) && (y_i < limit);

endmodule

`default_nettype wire

FILE: hw/rtl/aees_outq.sv
// Result queue: takes one or two items per cycle, hands out one if not stalled.
// Depends on aees_pkg for the result and push structs.
`default_nettype none

module aees_outq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  aees_pkg::push_t push_i,
  output logic           full_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output aees_pkg::rsp_t out_item_o
);
  import aees_pkg::*;

  localparam int unsigned PTR_W = $clog2(OQ_DEPTH);
  localparam int unsigned CNT_W = $clog2(OQ_DEPTH + 1);
  localparam logic [CNT_W-1:0] ROOM_LIMIT = CNT_W'(OQ_DEPTH - 2);

  rsp_t             mem_q [OQ_DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             pop;
  logic [CNT_W-1:0] npush;

  assign pop         = (cnt_q != '0) && !out_stall_i;
  assign out_valid_o = (cnt_q != '0);
  assign out_item_o  = mem_q[rd_q];
  assign full_o      = (cnt_q > ROOM_LIMIT);

  always_comb begin
    npush = '0;
    if (push_i.push) begin
      npush = push_i.two ? CNT_W'(2) : CNT_W'(1);
    end
    wr_d  = wr_q + PTR_W'(npush);
    rd_d  = rd_q + PTR_W'(pop);
    cnt_d = cnt_q + npush - CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.push) begin
      mem_q[wr_q] <= push_i.first;
      if (push_i.two) begin
        mem_q[wr_q + PTR_W'(1)] <= push_i.second;
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(OQ_DEPTH))
    else $error("result queue count beyond depth");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.push |-> (cnt_q <= ROOM_LIMIT))
    else $error("result pushed without room for two items");

endmodule

`default_nettype wire

FILE: hw/rtl/aees_ctrl.sv
// Alarm state machine, timers and configuration registers. Merges the
// lane near flags and builds the one or two result items of each item.
// Depends on aees_pkg.
`default_nettype none

module aees_ctrl #(
  parameter int unsigned LANES = aees_pkg::TARGETS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [aees_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [aees_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                          accept_i,
  input  aees_pkg::req_t                req_i,
  input  logic [LANES-1:0]              near_i,
  output logic [aees_pkg::DIST_W-1:0]   near_dist_o,
  output aees_pkg::push_t               push_o
);
  import aees_pkg::*;

  typedef enum logic [2:0] {
    ST_DISARMED,
    ST_ARMING,
    ST_ARMED,
    ST_PENDING,
    ST_TRIGGERED
  } mode_e;

  logic [DLY_W-1:0]  exit_dly_q, entry_dly_q, trig_to_q, loiter_thr_q;
  logic [DIST_W-1:0] near_dist_q;
  logic [OPT_W-1:0]  opt_q;

  mode_e             mode_q, mode_d;
  logic [TIME_W-1:0] time_q, time_d;
  logic [TIME_W-1:0] exit_start_q, exit_start_d, entry_start_q, entry_start_d;
  logic [TIME_W-1:0] trig_start_q, trig_start_d, loiter_start_q, loiter_start_d;
  logic [TIME_W-1:0] pres_start_q, pres_start_d, rem_last_q, rem_last_d;
  logic              home_q, home_d, siren_q, siren_d;
  logic              loiter_timing_q, loiter_timing_d, loitering_q, loitering_d;
  logic              pres_timing_q, pres_timing_d, pres_seen_q, pres_seen_d;

  logic [TIME_W-1:0] now;
  logic              close;
  event_e            ev_a, ev_b;
  rsp_t              status;

  assign now         = time_q + TIME_W'(req_i.req_type == REQ_TICK);
  assign close       = |near_i;
  assign near_dist_o = near_dist_q;

  always_comb begin
    logic [TIME_W-1:0] ls;
    mode_e             mid;
    mode_d          = mode_q;
    time_d          = time_q;
    exit_start_d    = exit_start_q;
    entry_start_d   = entry_start_q;
    trig_start_d    = trig_start_q;
    loiter_start_d  = loiter_start_q;
    pres_start_d    = pres_start_q;
    rem_last_d      = rem_last_q;
    home_d          = home_q;
    siren_d         = siren_q;
    loiter_timing_d = loiter_timing_q;
    loitering_d     = loitering_q;
    pres_timing_d   = pres_timing_q;
    pres_seen_d     = pres_seen_q;
    ev_a            = EV_NONE;
    ev_b            = EV_NONE;
    ls              = now;
    mid             = mode_q;
    if (accept_i) begin
      unique case (req_i.req_type)
        REQ_TICK: begin
          time_d = now;
          if (mode_q == ST_ARMING && (now - exit_start_q) >= TIME_W'(exit_dly_q)) begin
            mid  = ST_ARMED;
            ev_a = EV_ARMED_DELAY;
          end
          if (mode_q == ST_TRIGGERED && trig_to_q != '0 &&
              (now - trig_start_q) >= TIME_W'(trig_to_q)) begin
            siren_d = 1'b0;
            if (opt_q[OPT_AUTO_REARM]) begin
              mid  = ST_ARMED;
              ev_a = EV_SIL_REARM;
            end else begin
              mid  = ST_DISARMED;
              ev_a = EV_SIL_DISARM;
            end
          end
          if (mid == ST_DISARMED && opt_q[OPT_REMINDER] && pres_seen_q &&
              (now - rem_last_q) > REMINDER_MS) begin
            rem_last_d = now;
            ev_b       = EV_REMINDER;
          end
          mode_d = mid;
        end
        REQ_ARM: begin
          if (mode_q == ST_PENDING || mode_q == ST_TRIGGERED) begin
            ev_a = EV_REJECTED;
          end else begin
            home_d = req_i.home_request;
            if (req_i.immediate) begin
              mode_d = ST_ARMED;
              ev_a   = EV_ARMED_NOW;
            end else begin
              mode_d       = ST_ARMING;
              exit_start_d = now;
              ev_a         = EV_ARMING;
            end
            pres_seen_d   = 1'b0;
            pres_timing_d = 1'b0;
            pres_start_d  = '0;
            rem_last_d    = '0;
          end
        end
        REQ_DISARM: begin
          if (mode_q == ST_TRIGGERED) begin
            siren_d = 1'b0;
          end
          mode_d        = ST_DISARMED;
          home_d        = 1'b0;
          entry_start_d = '0;
          exit_start_d  = '0;
          pres_seen_d   = 1'b0;
          pres_timing_d = 1'b0;
          pres_start_d  = '0;
          rem_last_d    = '0;
          if (mode_q != ST_DISARMED) begin
            ev_a = EV_DISARMED;
          end
        end
        REQ_FRAME: begin
          if (close) begin
            ls              = loiter_timing_q ? loiter_start_q : now;
            loiter_start_d  = ls;
            loiter_timing_d = 1'b1;
            if ((now - ls) > TIME_W'(loiter_thr_q) && !loitering_q) begin
              loitering_d = 1'b1;
              if (opt_q[OPT_LOITER_ALR]) begin
                ev_a = EV_LOITER;
              end
            end
          end else begin
            loiter_timing_d = 1'b0;
            loitering_d     = 1'b0;
          end
          if (mode_q == ST_ARMED && req_i.target_count != '0 && !home_q) begin
            mode_d        = ST_PENDING;
            entry_start_d = now;
            ev_b          = EV_ENTRY;
          end else if (mode_q == ST_PENDING &&
                       (now - entry_start_q) >= TIME_W'(entry_dly_q)) begin
            mode_d       = ST_TRIGGERED;
            trig_start_d = now;
            ev_b         = EV_TRIGGERED;
            if (opt_q[OPT_SIREN]) begin
              siren_d = 1'b1;
            end
          end
          if (mode_q == ST_DISARMED && req_i.target_count != '0) begin
            if (!pres_timing_q) begin
              pres_start_d  = now;
              pres_timing_d = 1'b1;
            end else if ((now - pres_start_q) > PRESENCE_MS) begin
              pres_seen_d = 1'b1;
            end
          end else if (req_i.target_count == '0) begin
            pres_timing_d = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    status             = '0;
    status.panel_state = mode_d;
    status.home_active = home_d;
    status.siren_on    = siren_d;
    status.loiter_flag = loitering_d;
    status.last_result = 1'b1;
    push_o             = '0;
    push_o.push        = accept_i;
    push_o.first       = status;
    push_o.second      = status;
    if (ev_a != EV_NONE) begin
      push_o.first.event_code  = ev_a;
      push_o.second.event_code = ev_b;
      push_o.two               = (ev_b != EV_NONE);
      push_o.first.last_result = (ev_b == EV_NONE);
    end else begin
      push_o.first.event_code  = ev_b;
      push_o.second.event_code = EV_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exit_dly_q      <= EXIT_DELAY_RST;
      entry_dly_q     <= ENTRY_DELAY_RST;
      trig_to_q       <= TRIG_TIMEOUT_RST;
      loiter_thr_q    <= LOITER_THR_RST;
      near_dist_q     <= NEAR_DIST_RST;
      opt_q           <= OPTIONS_RST;
      mode_q          <= ST_DISARMED;
      time_q          <= '0;
      exit_start_q    <= '0;
      entry_start_q   <= '0;
      trig_start_q    <= '0;
      loiter_start_q  <= '0;
      pres_start_q    <= '0;
      rem_last_q      <= '0;
      home_q          <= 1'b0;
      siren_q         <= 1'b0;
      loiter_timing_q <= 1'b0;
      loitering_q     <= 1'b0;
      pres_timing_q   <= 1'b0;
      pres_seen_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_EXIT_DELAY:   exit_dly_q   <= cfg_wdata_i;
          CFG_ENTRY_DELAY:  entry_dly_q  <= cfg_wdata_i;
          CFG_TRIG_TIMEOUT: trig_to_q    <= cfg_wdata_i;
          CFG_LOITER_THR:   loiter_thr_q <= cfg_wdata_i;
          CFG_NEAR_DIST:    near_dist_q  <= cfg_wdata_i[DIST_W-1:0];
          CFG_OPTIONS:      opt_q        <= cfg_wdata_i[OPT_W-1:0];
          default: begin
          end
        endcase
      end
      mode_q          <= mode_d;
      time_q          <= time_d;
      exit_start_q    <= exit_start_d;
      entry_start_q   <= entry_start_d;
      trig_start_q    <= trig_start_d;
      loiter_start_q  <= loiter_start_d;
      pres_start_q    <= pres_start_d;
      rem_last_q      <= rem_last_d;
      home_q          <= home_d;
      siren_q         <= siren_d;
      loiter_timing_q <= loiter_timing_d;
      loitering_q     <= loitering_d;
      pres_timing_q   <= pres_timing_d;
      pres_seen_q     <= pres_seen_d;
    end
  end

  a_siren_trig: assert property (@(posedge clk_i) disable iff (!rst_ni)
    siren_q |-> (mode_q == ST_TRIGGERED))
    else $error("siren on outside the triggered state");

  a_loiter_timing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    loitering_q |-> loiter_timing_q)
    else $error("loitering flagged without a running loiter timer");

endmodule

`default_nettype wire

FILE: hw/rtl/alarm_entry_exit_state_machine_core.sv
// Alarm panel with entry and exit delays: usage summary.
// Input channel (in_valid_i, in_stall_o, in_item_i) carries ticks, arm and
// disarm commands and radar frames; each item yields one or two result
// items on the output channel (out_valid_o, out_stall_i, out_item_o),
// with last_result set on the final one.
// An accepted item settles the near-target lanes, state machine and timers
// in the same cycle and writes its results to a four-entry result queue.
// The first result is offered in the next cycle if the queue was empty.
// With single-result items and no output stall the block takes one item
// every cycle. in_stall_o rises when the queue has room for fewer than two
// results, so a stalling receiver holds results in the queue and then
// stalls the input. Configuration registers are written through cfg_we_i,
// cfg_idx_i and cfg_wdata_i; the user must do so only while the block is
// idle (not enforced by the block). Reset loads the register defaults, puts
// the panel in the disarmed state with all timers cleared, and empties the
// queue. Depends on aees_pkg, aees_lane, aees_ctrl and aees_outq.
`default_nettype none

module alarm_entry_exit_state_machine_core #(
  parameter int unsigned TARGETS = aees_pkg::TARGETS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [aees_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [aees_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  aees_pkg::req_t                in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output aees_pkg::rsp_t                out_item_o
);
  import aees_pkg::*;

  localparam int unsigned LANES = (TARGETS < NUM_TGT_FIELDS) ? TARGETS : NUM_TGT_FIELDS;

  logic               tgt_valid [NUM_TGT_FIELDS];
  logic signed [15:0] tgt_y     [NUM_TGT_FIELDS];
  logic [LANES-1:0]   near;
  logic [DIST_W-1:0]  near_dist;
  logic               accept;
  logic               full;
  push_t              push;

  assign tgt_valid[0] = in_item_i.t0_valid;
  assign tgt_valid[1] = in_item_i.t1_valid;
  assign tgt_valid[2] = in_item_i.t2_valid;
  assign tgt_y[0]     = in_item_i.t0_y;
  assign tgt_y[1]     = in_item_i.t1_y;
  assign tgt_y[2]     = in_item_i.t2_y;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    aees_lane u_lane (
      .valid_i     (tgt_valid[i]),
      .y_i         (tgt_y[i]),
      .near_dist_i (near_dist),
      .near_o      (near[i])
    );
  end

  aees_ctrl #(
    .LANES (LANES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .req_i       (in_item_i),
    .near_i      (near),
    .near_dist_o (near_dist),
    .push_o      (push)
  );

  aees_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

FILE: tb/tb_alarm_entry_exit_state_machine_core.sv
// Self-checking testbench for the alarm entry/exit state machine core.
// Drives ticks, arm/disarm commands and radar frames with random handshake gaps and
// checks every result item against a cycle-free model of the panel; uses aees_pkg.
module tb_alarm_entry_exit_state_machine_core;
  timeunit 1ns;
  timeprecision 1ps;

  import aees_pkg::*;

  typedef enum logic [2:0] {
    ST_DISARMED,
    ST_ARMING,
    ST_ARMED,
    ST_PENDING,
    ST_TRIGGERED
  } panel_state_e;

  typedef enum logic [1:0] {
    STEP_ITEM,
    STEP_CFG,
    STEP_DRAIN
  } step_kind_e;

  typedef struct packed {
    step_kind_e                 kind;
    req_t                       item;
    logic [CFG_IDX_W-1:0]       idx;
    logic [CFG_DATA_W-1:0]      wdata;
  } step_t;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;

  localparam int unsigned ITEM_TARGET   = 1900;
  localparam int unsigned SETTLE_CYCLES = 20;
  localparam int unsigned LIMIT_CYCLES  = 2_000_000;

  localparam int unsigned STYLE_MIN  = 0;
  localparam int unsigned STYLE_MAX  = 1;
  localparam int unsigned STYLE_RAND = 2;

  logic                  clk_i;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  req_t                  in_item_i   = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  rsp_t                  out_item_o;

  alarm_entry_exit_state_machine_core DUT (.*);

  logic [DLY_W-1:0]  exit_dly   = EXIT_DELAY_RST;
  logic [DLY_W-1:0]  entry_dly  = ENTRY_DELAY_RST;
  logic [DLY_W-1:0]  trig_tmo   = TRIG_TIMEOUT_RST;
  logic [DLY_W-1:0]  loiter_thr = LOITER_THR_RST;
  logic [DIST_W-1:0] near_mm    = NEAR_DIST_RST;
  logic [OPT_W-1:0]  opts       = OPTIONS_RST;

  logic [TIME_W-1:0] now_ms      = '0;
  logic [TIME_W-1:0] exit_t0     = '0;
  logic [TIME_W-1:0] entry_t0    = '0;
  logic [TIME_W-1:0] trig_t0     = '0;
  logic [TIME_W-1:0] loiter_t0   = '0;
  logic [TIME_W-1:0] presence_t0 = '0;
  logic [TIME_W-1:0] remind_t0   = '0;
  panel_state_e      mode        = ST_DISARMED;
  logic              home          = 1'b0;
  logic              loiter_run    = 1'b0;
  logic              loitering     = 1'b0;
  logic              presence_run  = 1'b0;
  logic              presence_seen = 1'b0;
  logic              siren         = 1'b0;

  event_e            ev_list [2];
  int unsigned       ev_cnt;

  rsp_t              predicted_rsp_q [$];
  step_t             panel_input_q [$];
  int unsigned       items_queued = 0;
  int unsigned       fail_cnt     = 0;
  bit                item_taken   = 1'b0;

  int unsigned       in_gap_left    = 0;
  int unsigned       in_calm        = 0;
  int unsigned       out_stall_left = 0;
  int unsigned       out_open_left  = 0;
  int unsigned       out_calm       = 0;

  function automatic logic [TIME_W-1:0] since(input logic [TIME_W-1:0] t0);
    return now_ms - t0;
  endfunction

  task automatic note_event(input event_e e);
    if (ev_cnt < 2) begin
      ev_list[ev_cnt] = e;
      ev_cnt++;
    end
  endtask

  task automatic clear_presence();
    presence_seen = 1'b0;
    presence_run  = 1'b0;
    presence_t0   = '0;
    remind_t0     = '0;
  endtask

  task automatic step_panel(input req_t it);
    logic [2:0]         vld;
    logic signed [15:0] ys [3];
    logic               near_hit;
    int                 yv;
    int                 nd;
    panel_state_e       prev;
    rsp_t               r;
    ev_cnt = 0;
    case (it.req_type)
      REQ_TICK: begin
        now_ms = now_ms + 1;
        if (mode == ST_ARMING && since(exit_t0) >= exit_dly) begin
          mode = ST_ARMED;
          note_event(EV_ARMED_DELAY);
        end
        if (mode == ST_TRIGGERED && trig_tmo != 0 && since(trig_t0) >= trig_tmo) begin
          siren = 1'b0;
          if (opts[OPT_AUTO_REARM]) begin
            mode = ST_ARMED;
            note_event(EV_SIL_REARM);
          end else begin
            mode = ST_DISARMED;
            note_event(EV_SIL_DISARM);
          end
        end
        if (mode == ST_DISARMED && opts[OPT_REMINDER] && presence_seen &&
            since(remind_t0) > REMINDER_MS) begin
          remind_t0 = now_ms;
          note_event(EV_REMINDER);
        end
      end
      REQ_ARM: begin
        if (mode == ST_PENDING || mode == ST_TRIGGERED) begin
          note_event(EV_REJECTED);
        end else begin
          home = it.home_request;
          if (it.immediate) begin
            mode = ST_ARMED;
            note_event(EV_ARMED_NOW);
          end else begin
            mode = ST_ARMING;
            exit_t0 = now_ms;
            note_event(EV_ARMING);
          end
          clear_presence();
        end
      end
      REQ_DISARM: begin
        prev = mode;
        if (prev == ST_TRIGGERED) siren = 1'b0;
        mode     = ST_DISARMED;
        home     = 1'b0;
        entry_t0 = '0;
        exit_t0  = '0;
        clear_presence();
        if (prev != ST_DISARMED) note_event(EV_DISARMED);
      end
      default: begin
        vld      = {it.t2_valid, it.t1_valid, it.t0_valid};
        ys[0]    = it.t0_y;
        ys[1]    = it.t1_y;
        ys[2]    = it.t2_y;
        nd       = near_mm;
        near_hit = 1'b0;
        for (int k = 0; k < TARGETS_DEF; k++) begin
          yv = ys[k];
          if (vld[k] && yv > 0 && yv < nd) near_hit = 1'b1;
        end
        if (near_hit) begin
          if (!loiter_run) begin
            loiter_t0  = now_ms;
            loiter_run = 1'b1;
          end
          if (since(loiter_t0) > loiter_thr && !loitering) begin
            loitering = 1'b1;
            if (opts[OPT_LOITER_ALR]) note_event(EV_LOITER);
          end
        end else begin
          loiter_run = 1'b0;
          loitering  = 1'b0;
        end
        if (mode == ST_ARMED && it.target_count != 0 && !home) begin
          mode     = ST_PENDING;
          entry_t0 = now_ms;
          note_event(EV_ENTRY);
        end else if (mode == ST_PENDING && since(entry_t0) >= entry_dly) begin
          mode    = ST_TRIGGERED;
          trig_t0 = now_ms;
          note_event(EV_TRIGGERED);
          if (opts[OPT_SIREN]) siren = 1'b1;
        end
        if (mode == ST_DISARMED && it.target_count != 0) begin
          if (!presence_run) begin
            presence_t0  = now_ms;
            presence_run = 1'b1;
          end else if (since(presence_t0) > PRESENCE_MS) begin
            presence_seen = 1'b1;
          end
        end else if (it.target_count == 0) begin
          presence_run = 1'b0;
        end
      end
    endcase
    if (ev_cnt == 0) note_event(EV_NONE);
    for (int k = 0; k < ev_cnt; k++) begin
      r.event_code  = ev_list[k];
      r.panel_state = mode;
      r.home_active = home;
      r.siren_on    = siren;
      r.loiter_flag = loitering;
      r.last_result = (k == ev_cnt - 1);
      predicted_rsp_q.push_back(r);
    end
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_cnt++;
    end
  endtask

  function automatic int unsigned pick_gap(inout int unsigned calm);
    int unsigned p;
    if (calm != 0) begin
      calm--;
      return 0;
    end
    p = $urandom_range(0, 99);
    if (p < 5) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin : watch
    rsp_t want;
    if (rst_ni) begin
      if ($isunknown({in_stall_o, out_valid_o})) begin
        $error("handshake output unknown: in_stall_o %b, out_valid_o %b",
               in_stall_o, out_valid_o);
        fail_cnt++;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_EXIT_DELAY:   exit_dly   = cfg_wdata_i;
          CFG_ENTRY_DELAY:  entry_dly  = cfg_wdata_i;
          CFG_TRIG_TIMEOUT: trig_tmo   = cfg_wdata_i;
          CFG_LOITER_THR:   loiter_thr = cfg_wdata_i;
          CFG_NEAR_DIST:    near_mm    = cfg_wdata_i[DIST_W-1:0];
          CFG_OPTIONS:      opts       = cfg_wdata_i[OPT_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_o) begin
        step_panel(in_item_i);
        item_taken = 1'b1;
      end
      if (out_valid_o && !out_stall_i) begin
        if (predicted_rsp_q.size() == 0) begin
          $error("result item with none expected: event_code %0d", out_item_o.event_code);
          fail_cnt++;
        end else begin
          want = predicted_rsp_q.pop_front();
          check_field("event_code", want.event_code, out_item_o.event_code);
          check_field("panel_state", want.panel_state, out_item_o.panel_state);
          check_field("home_active", want.home_active, out_item_o.home_active);
          check_field("siren_on", want.siren_on, out_item_o.siren_on);
          check_field("loiter_flag", want.loiter_flag, out_item_o.loiter_flag);
          check_field("last_result", want.last_result, out_item_o.last_result);
        end
      end
    end
  end

  always @(negedge clk_i) begin : drive
    step_t head;
    logic  nv;
    logic  nwe;
    nv  = in_valid_i && !item_taken;
    nwe = 1'b0;
    if (item_taken) begin
      item_taken  = 1'b0;
      in_gap_left = pick_gap(in_calm);
    end
    if (rst_ni && !nv && panel_input_q.size() != 0) begin
      head = panel_input_q[0];
      if (head.kind == STEP_ITEM) begin
        if (in_gap_left != 0) begin
          in_gap_left--;
        end else begin
          head = panel_input_q.pop_front();
          in_item_i <= head.item;
          nv = 1'b1;
        end
      end else if (predicted_rsp_q.size() == 0) begin
        head = panel_input_q.pop_front();
        if (head.kind == STEP_CFG) begin
          nwe = 1'b1;
          cfg_idx_i   <= head.idx;
          cfg_wdata_i <= head.wdata;
        end
      end
    end
    in_valid_i <= nv;
    cfg_we_i   <= nwe;
  end

  always @(negedge clk_i) begin : stall_gen
    if (out_stall_left != 0) begin
      out_stall_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
      if (out_open_left != 0) begin
        out_open_left--;
      end else begin
        out_stall_left = pick_gap(out_calm);
        out_open_left  = $urandom_range(0, 6);
      end
    end
  end

  task automatic push_item(input req_t it);
    step_t s = '0;
    s.kind = STEP_ITEM;
    s.item = it;
    panel_input_q.push_back(s);
    items_queued++;
  endtask

  task automatic push_reg(input logic [CFG_IDX_W-1:0] idx,
                          input logic [CFG_DATA_W-1:0] wdata);
    step_t s = '0;
    s.kind  = STEP_CFG;
    s.idx   = idx;
    s.wdata = wdata;
    panel_input_q.push_back(s);
  endtask

  task automatic push_drain();
    step_t s = '0;
    s.kind = STEP_DRAIN;
    panel_input_q.push_back(s);
  endtask

  function automatic req_t cmd(input req_e kind, input logic imm, input logic hm);
    req_t it = '0;
    it.req_type     = kind;
    it.immediate    = imm;
    it.home_request = hm;
    return it;
  endfunction

  function automatic req_t frame(input logic [1:0] cnt, input logic [2:0] v,
                                 input logic signed [15:0] y0, y1, y2);
    req_t it = '0;
    it.req_type     = REQ_FRAME;
    it.target_count = cnt;
    {it.t2_valid, it.t1_valid, it.t0_valid} = v;
    it.t0_y = y0;
    it.t1_y = y1;
    it.t2_y = y2;
    return it;
  endfunction

  function automatic req_t make_item(input req_e kind, input int unsigned bias,
                                     input logic [DIST_W-1:0] near);
    req_t               it;
    logic [63:0]        raw;
    logic signed [15:0] y [3];
    logic [2:0]         v;
    raw = {$urandom, $urandom};
    it = raw[$bits(req_t)-1:0];
    it.req_type = kind;
    for (int k = 0; k < 3; k++) begin
      if ($urandom_range(0, 99) < bias)
        y[k] = (near > 1) ? 16'($urandom_range(1, near - 1)) : 16'sd1;
      else
        y[k] = 16'($urandom);
      v[k] = ($urandom_range(0, 3) != 0);
    end
    {it.t2_valid, it.t1_valid, it.t0_valid} = v;
    it.t0_y = y[0];
    it.t1_y = y[1];
    it.t2_y = y[2];
    return it;
  endfunction

  task automatic add_settings(input int unsigned style, output logic [DIST_W-1:0] near);
    logic [DLY_W-1:0]      d [4];
    logic [OPT_W-1:0]      o;
    logic [CFG_DATA_W-1:0] w;
    int unsigned           p;
    for (int k = 0; k < 4; k++) begin
      p = $urandom_range(0, 99);
      if (style == STYLE_MIN || (style == STYLE_RAND && p < 6)) d[k] = '0;
      else if (style == STYLE_MAX || p < 10) d[k] = '1;
      else d[k] = DLY_W'($urandom_range(1, 25));
    end
    p = $urandom_range(0, 99);
    if (style == STYLE_MIN || (style == STYLE_RAND && p < 12)) near = DIST_W'(1);
    else if (style == STYLE_MAX || p < 24) near = '1;
    else near = DIST_W'($urandom_range(2, 4000));
    p = $urandom_range(0, 99);
    if (style == STYLE_MIN || (style == STYLE_RAND && p < 10)) o = '0;
    else if (style == STYLE_MAX || p < 20) o = '1;
    else o = OPT_W'($urandom_range(0, 15));
    push_reg(CFG_EXIT_DELAY, d[0]);
    push_reg(CFG_ENTRY_DELAY, d[1]);
    push_reg(CFG_TRIG_TIMEOUT, d[2]);
    push_reg(CFG_LOITER_THR, d[3]);
    w = CFG_DATA_W'($urandom);
    w[DIST_W-1:0] = near;
    push_reg(CFG_NEAR_DIST, w);
    w = CFG_DATA_W'($urandom);
    w[OPT_W-1:0] = o;
    push_reg(CFG_OPTIONS, w);
    if ($urandom_range(0, 2) == 0)
      push_reg(($urandom_range(0, 1) != 0) ? CFG_SPARE_6 : CFG_SPARE_7,
               CFG_DATA_W'($urandom));
  endtask

  task automatic add_scene(input logic [DIST_W-1:0] near);
    int unsigned len  = $urandom_range(4, 40);
    int unsigned bias = ($urandom_range(0, 1) != 0) ? 85 : 10;
    int unsigned p;
    req_t        it;
    it = make_item(REQ_ARM, bias, near);
    it.home_request = ($urandom_range(0, 4) == 0);
    push_item(it);
    repeat (len) begin
      p = $urandom_range(0, 99);
      if (p < 55) push_item(make_item(REQ_TICK, bias, near));
      else if (p < 92) push_item(make_item(REQ_FRAME, bias, near));
      else if (p < 96) push_item(make_item(REQ_ARM, bias, near));
      else push_item(make_item(REQ_DISARM, bias, near));
    end
    if ($urandom_range(0, 3) != 0) push_item(make_item(REQ_DISARM, bias, near));
  endtask

  initial begin : stim
    logic [DIST_W-1:0] near;
    int unsigned       style;

    push_item(cmd(REQ_TICK, 1'b0, 1'b0));
    push_item(cmd(REQ_DISARM, 1'b0, 1'b0));
    push_item(frame(2'd3, 3'b111, -16'sd32768, 16'sd32767, 16'sd0));
    push_item(frame(2'd0, 3'b001, 16'sd1999, 16'sd1, -16'sd1));
    push_item(cmd(REQ_ARM, 1'b1, 1'b1));
    push_item(frame(2'd3, 3'b111, 16'sd1, 16'sd1, 16'sd1));
    push_item(cmd(REQ_ARM, 1'b0, 1'b0));
    push_item(cmd(REQ_TICK, 1'b0, 1'b0));
    push_item(cmd(REQ_ARM, 1'b1, 1'b0));
    push_item(frame(2'd1, 3'b000, 16'sd100, 16'sd100, 16'sd100));
    push_item(cmd(REQ_ARM, 1'b1, 1'b0));
    push_item(cmd(REQ_DISARM, 1'b0, 1'b0));
    push_reg(CFG_EXIT_DELAY, 24'd1);
    push_reg(CFG_ENTRY_DELAY, 24'd1);
    push_reg(CFG_TRIG_TIMEOUT, 24'd2);
    push_reg(CFG_LOITER_THR, 24'd0);
    push_reg(CFG_NEAR_DIST, 24'd32767);
    push_reg(CFG_OPTIONS, 24'd15);
    push_item(cmd(REQ_ARM, 1'b0, 1'b0));
    push_item(cmd(REQ_TICK, 1'b0, 1'b0));
    push_item(frame(2'd2, 3'b001, 16'sd32766, 16'sd0, 16'sd0));
    push_item(cmd(REQ_TICK, 1'b0, 1'b0));
    push_item(frame(2'd2, 3'b001, 16'sd5, 16'sd0, 16'sd0));
    push_item(cmd(REQ_ARM, 1'b0, 1'b0));
    push_item(cmd(REQ_TICK, 1'b0, 1'b0));
    push_item(cmd(REQ_TICK, 1'b0, 1'b0));
    push_reg(CFG_OPTIONS, 24'hFFFFF0);
    push_reg(CFG_TRIG_TIMEOUT, 24'd1);
    push_reg(CFG_SPARE_6, 24'hFFFFFF);
    push_item(frame(2'd1, 3'b000, 16'sd0, 16'sd0, 16'sd0));
    push_item(cmd(REQ_TICK, 1'b0, 1'b0));
    push_item(frame(2'd1, 3'b000, 16'sd0, 16'sd0, 16'sd0));
    push_item(cmd(REQ_TICK, 1'b0, 1'b0));

    style = STYLE_MIN;
    while (items_queued < ITEM_TARGET) begin
      add_settings(style, near);
      style = (style == STYLE_MIN) ? STYLE_MAX : STYLE_RAND;
      repeat ($urandom_range(4, 12)) begin
        if (items_queued >= ITEM_TARGET) break;
        if ($urandom_range(0, 9) == 0)
          push_item(make_item(req_e'($urandom_range(0, 3)), 30, near));
        else
          add_scene(near);
        if ($urandom_range(0, 5) == 0) push_drain();
      end
    end

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (panel_input_q.size() != 0 || in_valid_i || predicted_rsp_q.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0)
      $display("alarm_entry_exit_state_machine_core verification clean");
    else
      $display("alarm_entry_exit_state_machine_core verification failed");
    $finish;
  end

  initial begin : watchdog
    repeat (LIMIT_CYCLES) @(posedge clk_i);
    $display("alarm_entry_exit_state_machine_core verification failed");
    $finish;
  end

endmodule
